### rtl/core/ial_pkg.sv
// Shared types and codes for the indexed array list and its storage cells.
package ial_pkg;

  // Request codes carried on the request channel.
  typedef enum logic [2:0] {
    REQ_PUSH_BACK  = 3'd0,
    REQ_PUSH_FRONT = 3'd1,
    REQ_POP_BACK   = 3'd2,
    REQ_POP_FRONT  = 3'd3,
    REQ_INSERT     = 3'd4,
    REQ_SET        = 3'd5,
    REQ_GET        = 3'd6
  } req_type_e;

  // Status codes returned with every response.
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2,
    ST_FULL  = 2'd3
  } status_e;

  // Command broadcast to every cell of the chain.
  typedef enum logic [1:0] {
    CELL_HOLD  = 2'd0,
    CELL_OPEN  = 2'd1,
    CELL_CLOSE = 2'd2,
    CELL_WRITE = 2'd3
  } cell_cmd_e;

  // Width of the slot index shared by all cells.
  localparam int unsigned PosW = 8;

  typedef struct packed {
    cell_cmd_e         cmd;
    logic [PosW-1:0]   pos;
  } cell_ctrl_t;

endpackage

### rtl/core/ial_cell.sv
// One storage slot of the list, trading words with its two neighbors.
module ial_cell #(
  parameter int unsigned Index = 0,
  parameter int unsigned WordW = 32
) (
  input  logic                clk_i,
  input  ial_pkg::cell_ctrl_t ctrl_i,
  input  logic [WordW-1:0]    word_i,
  input  logic [WordW-1:0]    lower_i,
  input  logic [WordW-1:0]    upper_i,
  output logic [WordW-1:0]    entry_o
);

  logic [WordW-1:0]         entry_q;
  logic [WordW-1:0]         entry_d;
  logic [ial_pkg::PosW-1:0] my_idx;

  assign my_idx = ial_pkg::PosW'(Index);

  // Pick the next word: keep, take a neighbor's word, or load the new word.
  always_comb begin
    entry_d = entry_q;
    case (ctrl_i.cmd)
      ial_pkg::CELL_OPEN: begin
        if (my_idx == ctrl_i.pos) begin
          entry_d = word_i;
        end else if (my_idx > ctrl_i.pos) begin
          entry_d = lower_i;
        end
      end
      ial_pkg::CELL_CLOSE: begin
        entry_d = upper_i;
      end
      ial_pkg::CELL_WRITE: begin
        if (my_idx == ctrl_i.pos) begin
          entry_d = word_i;
        end
      end
      default: begin
        entry_d = entry_q;
      end
    endcase
  end

  // Payload storage, undefined until written.
  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

### rtl/core/indexed_array_list.sv
// Indexed array list: a fixed-capacity ordered list of words in a chain of shift cells.
// Each request's response is registered and appears in the cycle after the request is taken.
// Throughput is one request per cycle unless the output stalls; cells shift later entries on accept.
// The request side stalls only while a finished response is held by a stalled consumer.
// Reset empties the list and drops any pending response; the stored words are not cleared.
module indexed_array_list #(
  parameter int unsigned CAPACITY   = 16,
  parameter int unsigned WORD_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  req_type_i,
  input  logic [7:0]  position_i,
  input  logic [31:0] value_in_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [31:0] value_out_o,
  output logic [4:0]  count_o
);

  localparam int unsigned StoreW = (WORD_WIDTH < 32) ? WORD_WIDTH : 32;
  localparam int unsigned CntW   = $clog2(CAPACITY + 1);
  localparam int unsigned IdxW   = $clog2(CAPACITY);
  localparam int unsigned CmpW   = (CntW > 8) ? CntW : 8;

  logic [CntW-1:0]     fill_q;
  logic [CntW-1:0]     fill_d;
  logic                out_valid_q;
  logic [1:0]          status_q;
  logic [31:0]         value_q;
  logic [4:0]          count_q;

  logic                accept;
  logic                full;
  logic                empty;
  logic [CmpW-1:0]     fill_ext;
  logic [CmpW-1:0]     pos_ext;
  logic [StoreW-1:0]   word_in;
  logic [StoreW-1:0]   rd_word;
  ial_pkg::status_e    status_d;
  logic [31:0]         value_d;
  ial_pkg::cell_ctrl_t ctrl;
  ial_pkg::cell_cmd_e  cmd;

  logic [StoreW-1:0]   entry [CAPACITY];

  // A transfer is taken unless a finished response is stuck at the output.
  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  assign full     = (fill_q == CntW'(CAPACITY));
  assign empty    = (fill_q == '0);
  assign fill_ext = CmpW'(fill_q);
  assign pos_ext  = CmpW'(position_i);
  assign word_in  = StoreW'(value_in_i);
  assign rd_word  = entry[position_i[IdxW-1:0]];

  // Decode the request into a status, a new fill count and a cell command.
  always_comb begin
    status_d = ial_pkg::ST_OK;
    value_d  = '0;
    fill_d   = fill_q;
    cmd      = ial_pkg::CELL_HOLD;
    ctrl.pos = position_i;
    case (ial_pkg::req_type_e'(req_type_i))
      ial_pkg::REQ_PUSH_BACK: begin
        if (full) begin
          status_d = ial_pkg::ST_FULL;
        end else begin
          cmd      = ial_pkg::CELL_OPEN;
          ctrl.pos = ial_pkg::PosW'(fill_q);
          fill_d   = fill_q + 1'b1;
        end
      end
      ial_pkg::REQ_PUSH_FRONT: begin
        if (full) begin
          status_d = ial_pkg::ST_FULL;
        end else begin
          cmd      = ial_pkg::CELL_OPEN;
          ctrl.pos = '0;
          fill_d   = fill_q + 1'b1;
        end
      end
      ial_pkg::REQ_POP_BACK: begin
        if (empty) begin
          status_d = ial_pkg::ST_EMPTY;
        end else begin
          fill_d = fill_q - 1'b1;
        end
      end
      ial_pkg::REQ_POP_FRONT: begin
        if (empty) begin
          status_d = ial_pkg::ST_EMPTY;
        end else begin
          cmd    = ial_pkg::CELL_CLOSE;
          fill_d = fill_q - 1'b1;
        end
      end
      ial_pkg::REQ_INSERT: begin
        if (pos_ext > fill_ext) begin
          status_d = ial_pkg::ST_RANGE;
        end else if (full) begin
          status_d = ial_pkg::ST_FULL;
        end else begin
          cmd    = ial_pkg::CELL_OPEN;
          fill_d = fill_q + 1'b1;
        end
      end
      ial_pkg::REQ_SET: begin
        if (pos_ext >= fill_ext) begin
          status_d = ial_pkg::ST_RANGE;
        end else begin
          cmd = ial_pkg::CELL_WRITE;
        end
      end
      ial_pkg::REQ_GET: begin
        if (pos_ext >= fill_ext) begin
          status_d = ial_pkg::ST_RANGE;
        end else begin
          value_d = 32'(rd_word);
        end
      end
      default: begin
        status_d = ial_pkg::ST_OK;
      end
    endcase
    ctrl.cmd = accept ? cmd : ial_pkg::CELL_HOLD;
  end

  // Chain of storage cells; each sees its lower and upper neighbor (zero below the first, itself above the last).
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [StoreW-1:0] lower;
    logic [StoreW-1:0] upper;
    if (i == 0) begin : g_first
      assign lower = '0;
    end else begin : g_mid_lo
      assign lower = entry[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign upper = entry[i];
    end else begin : g_mid_hi
      assign upper = entry[i+1];
    end
    ial_cell #(
      .Index (i),
      .WordW (StoreW)
    ) u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .word_i  (word_in),
      .lower_i (lower),
      .upper_i (upper),
      .entry_o (entry[i])
    );
  end

  // Fill count and response valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        fill_q <= fill_d;
      end
      out_valid_q <= accept || (out_valid_q && out_stall_i);
    end
  end

  // Response payload.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
      value_q  <= value_d;
      count_q  <= 5'(fill_d);
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign value_out_o = value_q;
  assign count_o     = count_q;

endmodule
